@@ src/lbs_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the skinning engine
package lbs_pkg;

  localparam int NUM_BONES      = 64;
  localparam int MAX_INFLUENCES = 4;
  localparam int FRAC_BITS      = 16;
  localparam int WEIGHT_FRAC    = 15;
  localparam int NUM_ELEMS      = 12;
  localparam int BONE_W         = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
  localparam int SLOT_W         = 2;
  localparam int CNT_W          = 3;
  localparam int ACC_W          = 36;
  localparam logic [7:0] END_ID = 8'd255;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_POINT = 2'd1,
    OP_DIR   = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         bone_select;
    logic [3:0]         element_select;
    logic signed [31:0] matrix_value;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [31:0]        influence_ids;
    logic [63:0]        influence_weights;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               was_direction;
  } out_beat_t;

  typedef logic [NUM_ELEMS-1:0][31:0] row_t;

  // one bone read travelling down the arithmetic pipe
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic               none;
    logic               is_point;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [15:0]        weight;
  } meta_t;

endpackage

@@ src/lbs_store.sv @@
`timescale 1ns / 1ps
// bone matrix store: element write port, whole-matrix registered read port
module lbs_store import lbs_pkg::*; (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [BONE_W-1:0] wr_bone_i,
  input  logic [3:0]        wr_elem_i,
  input  logic [31:0]       wr_data_i,
  input  logic              rd_en_i,
  input  logic [BONE_W-1:0] rd_bone_i,
  output row_t              rd_row_o
);

  row_t mem_q [NUM_BONES];
  row_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_bone_i][wr_elem_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_bone_i];
    end
  end

  assign rd_row_o = rd_q;

endmodule

@@ src/lbs_seq.sv @@
`timescale 1ns / 1ps
// input holding register and influence sequencer, one bone read per cycle while the pipe advances
module lbs_seq import lbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_beat_t          in_beat_i,
  output logic              wr_en_o,
  output logic [BONE_W-1:0] wr_bone_o,
  output logic [3:0]        wr_elem_o,
  output logic [31:0]       wr_data_o,
  output logic              rd_en_o,
  output logic [BONE_W-1:0] rd_bone_o,
  output meta_t             meta_o
);

  in_beat_t          item_q;
  logic              hold_q, hold_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  meta_t             meta_q, meta_d;

  logic [CNT_W-1:0]  cnt;
  logic              stop;
  logic [7:0]        id_k, id_cur;
  logic              is_skin, none, last, done, accept;

  // number of leading usable influence slots
  always_comb begin
    cnt  = '0;
    stop = 1'b0;
    for (int k = 0; k < MAX_INFLUENCES; k++) begin
      id_k = item_q.influence_ids[k*8 +: 8];
      if (!stop && id_k != END_ID && {1'b0, id_k} < 9'(NUM_BONES)) begin
        cnt = cnt + CNT_W'(1);
      end else begin
        stop = 1'b1;
      end
    end
  end

  assign id_cur  = item_q.influence_ids[slot_q*8 +: 8];
  assign is_skin = (item_q.operation == OP_POINT) || (item_q.operation == OP_DIR);
  assign none    = (cnt == '0);
  assign last    = ({1'b0, slot_q} + CNT_W'(1)) == cnt;
  assign done    = !is_skin || none || last;

  assign in_stall_o = !adv_i || (hold_q && !done);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    hold_d = hold_q;
    slot_d = slot_q;
    if (accept) begin
      hold_d = 1'b1;
      slot_d = '0;
    end else if (adv_i && hold_q) begin
      if (done) begin
        hold_d = 1'b0;
      end else begin
        slot_d = slot_q + SLOT_W'(1);
      end
    end
  end

  always_comb begin
    meta_d          = meta_q;
    if (adv_i) begin
      meta_d.valid    = hold_q && is_skin;
      meta_d.first    = (slot_q == '0);
      meta_d.last     = done;
      meta_d.none     = none;
      meta_d.is_point = (item_q.operation == OP_POINT);
      meta_d.vx       = item_q.vec_x;
      meta_d.vy       = item_q.vec_y;
      meta_d.vz       = item_q.vec_z;
      meta_d.weight   = item_q.influence_weights[slot_q*16 +: 16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      slot_q <= '0;
      meta_q <= '0;
    end else begin
      hold_q <= hold_d;
      slot_q <= slot_d;
      meta_q <= meta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_beat_i;
    end
  end

  assign wr_en_o   = adv_i && hold_q && (item_q.operation == OP_WRITE) &&
                     ({1'b0, item_q.bone_select} < 7'(NUM_BONES)) &&
                     (item_q.element_select < 4'(NUM_ELEMS));
  assign wr_bone_o = item_q.bone_select[BONE_W-1:0];
  assign wr_elem_o = item_q.element_select;
  assign wr_data_o = item_q.matrix_value;
  assign rd_en_o   = adv_i && hold_q && is_skin && !none;
  assign rd_bone_o = id_cur[BONE_W-1:0];
  assign meta_o    = meta_q;

endmodule

@@ src/lbs_math.sv @@
`timescale 1ns / 1ps
// matrix-vector products, row saturation, weighting and accumulation
module lbs_math import lbs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  meta_t     meta_i,
  input  row_t      row_i,
  output logic      out_valid_o,
  output out_beat_t out_beat_o
);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // stage 2: products
  logic signed [63:0] p_q [3][3];
  logic signed [31:0] tr_q [3];
  meta_t              m2_q;
  // stage 3: saturated row sums
  logic signed [31:0] t_q [3];
  meta_t              m3_q;
  // stage 4: weighted rows
  logic signed [48:0] wp_q [3];
  meta_t              m4_q;

  logic signed [ACC_W-1:0] acc_q [3];
  logic signed [ACC_W-1:0] acc_n [3];
  logic signed [63:0]      rsum [3];
  logic signed [31:0]      vsel [3];
  logic                    out_valid_q, out_valid_d;
  out_beat_t               out_q;

  assign vsel[0] = meta_i.vx;
  assign vsel[1] = meta_i.vy;
  assign vsel[2] = meta_i.vz;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_q[r][c] <= $signed(row_i[r*4 + c]) * vsel[c];
        end
        tr_q[r] <= $signed(row_i[r*4 + 3]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum[r] = (p_q[r][0] >>> FRAC_BITS) + (p_q[r][1] >>> FRAC_BITS) +
                (p_q[r][2] >>> FRAC_BITS) +
                (m2_q.is_point ? 64'(tr_q[r]) : 64'sd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int r = 0; r < 3; r++) begin
        // no influences: row term is zero
        t_q[r] <= m2_q.none ? 32'sd0 : sat32(rsum[r]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int r = 0; r < 3; r++) begin
        wp_q[r] <= t_q[r] * $signed({1'b0, m3_q.weight});
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_n[r] = (m4_q.first ? ACC_W'(0) : acc_q[r]) + ACC_W'(wp_q[r] >>> WEIGHT_FRAC);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_q <= '0;
      m3_q <= '0;
      m4_q <= '0;
    end else if (adv_i) begin
      m2_q <= meta_i;
      m3_q <= m2_q;
      m4_q <= m3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && m4_q.valid) begin
      for (int r = 0; r < 3; r++) begin
        acc_q[r] <= acc_n[r];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && m4_q.valid && m4_q.last) begin
      out_q.out_x         <= sat32(64'(acc_n[0]));
      out_q.out_y         <= sat32(64'(acc_n[1]));
      out_q.out_z         <= sat32(64'(acc_n[2]));
      out_q.was_direction <= !m4_q.is_point;
    end
  end

  assign out_valid_d = adv_i ? (m4_q.valid && m4_q.last) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

@@ src/linear_blend_skinning.sv @@
`timescale 1ns / 1ps
// Four-influence linear blend skinning engine. Write beats load one element of a
// bone matrix; skin beats return one Q16.16 xyz result. The matrix store has a
// single read port that delivers a whole bone matrix per cycle, so a skin beat
// with n usable influences issues n bone reads and holds the sequencer until
// the last one; while the output is not stalled, write beats and skins with
// at most one influence go at one beat per cycle; a stalled output holds the
// whole pipe. Results are registered; unwritten matrix entries read as garbage.
module linear_blend_skinning import lbs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic              adv;
  logic              wr_en, rd_en;
  logic [BONE_W-1:0] wr_bone, rd_bone;
  logic [3:0]        wr_elem;
  logic [31:0]       wr_data;
  row_t              row;
  meta_t             meta;

  assign adv = !(out_valid_o && out_stall_i);

  lbs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .wr_en_o    (wr_en),
    .wr_bone_o  (wr_bone),
    .wr_elem_o  (wr_elem),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_bone_o  (rd_bone),
    .meta_o     (meta)
  );

  lbs_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_bone_i (wr_bone),
    .wr_elem_i (wr_elem),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_bone_i (rd_bone),
    .rd_row_o  (row)
  );

  lbs_math u_math (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .meta_i      (meta),
    .row_i       (row),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );

endmodule

@@ src/lbs_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the skinning engine and their bind
module lbs_checker import lbs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_beat_o
);

  // a waiting result is held with its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("result beat dropped or changed while stalled");

  // a blocked output freezes the pipe, so no input beat may enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input beat taken while output blocked");

  // no result can come out of an empty pipe right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat right after reset");

endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);
